// File: src/ptts_pkg.sv
// Shared types and constants for the periodic task timer scheduler.
// No dependencies; used by ptts_ctrl, ptts_dp and the top level.
package ptts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int ID_W   = 8;
  localparam int TIME_W = 32;
  localparam int DLY_W  = 24;

  // Input opcodes (in_tuser)
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds (out_tuser)
  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic add;       // store input task in lowest free slot
    logic load_rej;  // latch id of a rejected add
    logic tick;      // advance time, start due scan
    logic due_step;  // evaluate due bit of one slot
    logic sel_step;  // compare one slot against current best
    logic fire;      // emit best task, re-arm or free it
    logic reject;    // emit reject word
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic free_any;   // at least one free slot
    logic scan_last;  // scan index at last slot
    logic found;      // a due task was selected
    logic out_free;   // output register can take a word
    logic fire_last;  // selected task is the last due one
  } status_t;

endpackage

// File: src/ptts_dp.sv
// Datapath: time counter, task table, due scan, earliest-deadline search
// and output register. Depends on ptts_pkg; driven by ptts_ctrl commands.
module ptts_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptts_pkg::cmd_t              cmd,
  output ptts_pkg::status_t           status,
  input  logic [ptts_pkg::ID_W-1:0]   in_task_id,
  input  logic [ptts_pkg::DLY_W-1:0]  in_delay,
  input  logic                        in_repeat_req,
  input  logic                        out_tready,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [ptts_pkg::ID_W-1:0]   out_id,
  output logic                        out_last
);

  localparam int PAD_W = ptts_pkg::TIME_W - ptts_pkg::DLY_W;

  // Task table
  logic [ptts_pkg::SLOTS-1:0]                      valid_r;
  logic [ptts_pkg::SLOTS-1:0]                      repeat_r;
  logic [ptts_pkg::SLOTS-1:0][ptts_pkg::TIME_W-1:0] deadline_r;
  logic [ptts_pkg::SLOTS-1:0][ptts_pkg::DLY_W-1:0]  interval_r;
  logic [ptts_pkg::SLOTS-1:0][ptts_pkg::ID_W-1:0]   ident_r;

  // Scan state
  logic [ptts_pkg::TIME_W-1:0] time_r;
  logic [ptts_pkg::SLOTS-1:0]  due_r;
  logic [ptts_pkg::SLOT_W-1:0] idx_r;
  logic [ptts_pkg::SLOT_W-1:0] best_r;
  logic [ptts_pkg::TIME_W-1:0] best_age_r;
  logic                        found_r;
  logic [ptts_pkg::ID_W-1:0]   rej_id_r;

  // Output register
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [ptts_pkg::ID_W-1:0]   out_id_r;
  logic                        out_last_r;

  logic [ptts_pkg::SLOT_W-1:0] free_idx;
  logic                        free_any;
  logic [ptts_pkg::TIME_W-1:0] age;
  logic [ptts_pkg::SLOTS-1:0]  best_oh;
  logic                        fire_last;
  logic                        out_free;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = ptts_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = ptts_pkg::SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // Age of the scanned slot; due when below half the counter range
  assign age       = time_r - deadline_r[idx_r];
  assign best_oh   = ptts_pkg::SLOTS'(1) << best_r;
  assign fire_last = ((due_r & ~best_oh) == '0);
  assign out_free  = !out_valid_r || out_tready;

  assign status.free_any  = free_any;
  assign status.scan_last = (idx_r == ptts_pkg::SLOT_W'(ptts_pkg::SLOTS - 1));
  assign status.found     = found_r;
  assign status.out_free  = out_free;
  assign status.fire_last = fire_last;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      valid_r     <= '0;
      due_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (cmd.tick) begin
        time_r  <= time_r + 1'b1;
        idx_r   <= '0;
        due_r   <= '0;
        found_r <= 1'b0;
      end
      if (cmd.due_step) begin
        due_r[idx_r] <= valid_r[idx_r] && !age[ptts_pkg::TIME_W-1];
        idx_r        <= idx_r + 1'b1;
      end
      if (cmd.sel_step) begin
        if (due_r[idx_r] && (!found_r || age > best_age_r)) begin
          found_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.fire) begin
        due_r[best_r] <= 1'b0;
        idx_r         <= '0;
        found_r       <= 1'b0;
        if (!repeat_r[best_r]) begin
          valid_r[best_r] <= 1'b0;
        end
      end
      // output word valid
      if (cmd.fire || cmd.reject) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      deadline_r[free_idx] <= time_r + {{PAD_W{1'b0}}, in_delay};
      interval_r[free_idx] <= in_delay;
      repeat_r[free_idx]   <= in_repeat_req;
      ident_r[free_idx]    <= in_task_id;
    end
    if (cmd.load_rej) begin
      rej_id_r <= in_task_id;
    end
    if (cmd.sel_step && due_r[idx_r] && (!found_r || age > best_age_r)) begin
      best_r     <= idx_r;
      best_age_r <= age;
    end
    if (cmd.fire) begin
      if (repeat_r[best_r]) begin
        deadline_r[best_r] <= time_r + {{PAD_W{1'b0}}, interval_r[best_r]};
      end
      out_kind_r <= ptts_pkg::KIND_FIRED;
      out_id_r   <= ident_r[best_r];
      out_last_r <= fire_last;
    end else if (cmd.reject) begin
      out_kind_r <= ptts_pkg::KIND_REJECT;
      out_id_r   <= rej_id_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_id    = out_id_r;
  assign out_last  = out_last_r;

endmodule

// File: src/ptts_ctrl.sv
// Controller: sequences add, tick scan, selection and emission; holds the
// enable register. Depends on ptts_pkg; drives ptts_dp.
module ptts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_opcode,
  output logic               in_ready,
  input  logic               cfg_valid,
  input  logic               cfg_enabled,
  output logic               cfg_ready,
  input  ptts_pkg::status_t  status,
  output ptts_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DUE  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_REJ  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       enabled_r;
  logic       acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_ready && in_valid;

  // Enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
    end else if (cfg_valid) begin
      enabled_r <= cfg_enabled;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_opcode == ptts_pkg::OP_ADD) begin
            if (status.free_any) begin
              cmd.add = 1'b1;
            end else begin
              cmd.load_rej = 1'b1;
              state_nxt    = ST_REJ;
            end
          end else if (enabled_r) begin
            cmd.tick  = 1'b1;
            state_nxt = ST_DUE;
          end
        end
      end
      ST_DUE: begin
        cmd.due_step = 1'b1;
        if (status.scan_last) state_nxt = ST_SEL;
      end
      ST_SEL: begin
        cmd.sel_step = 1'b1;
        if (status.scan_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.found) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.fire  = 1'b1;
          state_nxt = status.fire_last ? ST_IDLE : ST_SEL;
        end
      end
      ST_REJ: begin
        if (status.out_free) begin
          cmd.reject = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/periodic_task_timer_scheduler.sv
// Periodic task timer scheduler: 16-slot table of timed tasks with a
// millisecond counter, firing due tasks earliest deadline first.
//
// Input channel (in_*): one word per item. tuser is the opcode (add or tick).
// An add stores the task in the lowest free slot with no result,
// or emits one reject word (tuser 1) when the table is full.
// A tick (when enabled) advances time, marks due slots in a pass over
// the table, then for each due task scans the table for the earliest
// deadline and emits it; with nothing due, the tick ends after one empty
// scan and its check.
// Output channel (out_*): one word per result in a holding register; tlast
// marks the final word of an item. A stalled receiver holds the emit step.
// Config channel (cfg_*): one bit, the enable; the user must write it only
// while idle, and the block itself does not enforce this.
// Reset (rst_n low, synchronous): time zero, all slots free, enable set.
// Reset takes no clearing pass.
module periodic_task_timer_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // task_id[7:0], delay[31:8], repeat_req[32], zero pad
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // task_id[7:0] of the fired or rejected task
  output logic        out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  ptts_pkg::cmd_t    cmd;
  ptts_pkg::status_t status;

  ptts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_opcode   (in_tuser),
    .in_ready    (in_tready),
    .cfg_valid   (cfg_valid),
    .cfg_enabled (cfg_data),
    .cfg_ready   (cfg_ready),
    .status      (status),
    .cmd         (cmd)
  );

  ptts_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_task_id    (in_tdata[7:0]),
    .in_delay      (in_tdata[31:8]),
    .in_repeat_req (in_tdata[32]),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_kind      (out_tuser),
    .out_id        (out_tdata),
    .out_last      (out_tlast)
  );

endmodule

// File: tb/sv/periodic_task_timer_scheduler_tb.sv
// Self-checking bench for periodic_task_timer_scheduler: directed and random add/tick words,
// enable toggling between phases, results checked against an in-bench table model.
// Depends on src/ptts_pkg.sv and the scheduler RTL.
`timescale 1ns / 1ps

module periodic_task_timer_scheduler_tb;

  localparam int  RESET_CYCLES = 11;
  localparam int  DRAIN_CYCLES = 300;     // time for the longest tick to end
  localparam int  PHASES       = 10;
  localparam int  PHASE_WORDS  = 30;
  localparam int  STICKY_MAX   = 6;       // random tasks that may hold a slot for good
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic                       op;
    logic [ptts_pkg::ID_W-1:0]  task_id;
    logic [ptts_pkg::DLY_W-1:0] delay;
    logic                       rep;
  } sched_item_t;

  typedef struct packed {
    logic                      kind;
    logic [ptts_pkg::ID_W-1:0] id;
    logic                      last;
  } fire_rec_t;

  // DUT inputs start known
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_tready, out_tvalid, out_tuser, out_tlast, cfg_ready;
  logic [7:0]  out_tdata;

  periodic_task_timer_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Stimulus and expectation stores
  sched_item_t word_q[$];
  fire_rec_t   fire_q[$];
  sched_item_t offer;
  int          words_queued = 0;
  int          words_sent = 0;
  int          errors = 0;
  int          fired_seen = 0;
  int          reject_seen = 0;
  int          cfg_writes = 0;
  int          sticky = 0;
  bit          idle_on = 1'b0;
  longint      cycles = 0;

  // Table model
  logic                        en_model = 1'b1;
  logic [ptts_pkg::TIME_W-1:0] now_ms = '0;
  logic                        tbl_valid    [ptts_pkg::SLOTS];
  logic [ptts_pkg::TIME_W-1:0] tbl_deadline [ptts_pkg::SLOTS];
  logic [ptts_pkg::DLY_W-1:0]  tbl_interval [ptts_pkg::SLOTS];
  logic                        tbl_repeat   [ptts_pkg::SLOTS];
  logic [ptts_pkg::ID_W-1:0]   tbl_ident    [ptts_pkg::SLOTS];

  initial begin
    for (int i = 0; i < ptts_pkg::SLOTS; i++) tbl_valid[i] = 1'b0;
  end

  // Apply one accepted word to the table and queue the words it should produce
  task automatic apply_item(input sched_item_t it);
    logic                        due [ptts_pkg::SLOTS];
    logic [ptts_pkg::ID_W-1:0]   ids [ptts_pkg::SLOTS];
    logic [ptts_pkg::TIME_W-1:0] age, best_age;
    int                          n, best;
    n = 0;
    if (it.op == ptts_pkg::OP_ADD) begin
      for (int i = 0; i < ptts_pkg::SLOTS; i++) begin
        if (!tbl_valid[i]) begin
          tbl_valid[i]    = 1'b1;
          tbl_deadline[i] = now_ms + ptts_pkg::TIME_W'(it.delay);
          tbl_interval[i] = it.delay;
          tbl_repeat[i]   = it.rep;
          tbl_ident[i]    = it.task_id;
          return;
        end
      end
      fire_q.push_back(fire_rec_t'{ptts_pkg::KIND_REJECT, it.task_id, 1'b1});
      return;
    end
    if (!en_model) return;
    now_ms = now_ms + 1;
    // due set is frozen for the whole tick
    for (int i = 0; i < ptts_pkg::SLOTS; i++)
      due[i] = tbl_valid[i] && ((now_ms - tbl_deadline[i]) < 32'h8000_0000);
    while (n < ptts_pkg::SLOTS) begin
      best = -1;
      best_age = '0;
      for (int i = 0; i < ptts_pkg::SLOTS; i++) begin
        if (due[i]) begin
          age = now_ms - tbl_deadline[i];
          if (best < 0 || age > best_age) begin
            best = i;
            best_age = age;
          end
        end
      end
      if (best < 0) break;
      due[best] = 1'b0;
      ids[n] = tbl_ident[best];
      n++;
      if (tbl_repeat[best])
        tbl_deadline[best] = now_ms + ptts_pkg::TIME_W'(tbl_interval[best]);
      else tbl_valid[best] = 1'b0;
    end
    for (int k = 0; k < n; k++)
      fire_q.push_back(fire_rec_t'{ptts_pkg::KIND_FIRED, ids[k], k == n - 1});
  endtask

  task automatic push_item(input logic op, input logic [ptts_pkg::ID_W-1:0] id,
                           input logic [ptts_pkg::DLY_W-1:0] dly, input logic rep);
    word_q.push_back(sched_item_t'{op, id, dly, rep});
    words_queued++;
  endtask

  // Wait until all words are in, all results out, and a full tick has had time to end
  task automatic wait_idle();
    while (words_sent != words_queued || fire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    en_model = v;
    cfg_writes++;
  endtask

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Input driver: one word per handshake, random gap after each while idle_on is set
  always @(posedge clk) begin : drv
    bit held;
    int gap_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      held = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) begin
        apply_item(offer);
        words_sent++;
      end
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (word_q.size() > 0) begin
          offer = word_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'b0, offer.rep, offer.delay, offer.task_id};
          in_tuser  <= offer.op;
          gap_left = idle_on ? $urandom_range(0, 5) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each word with the oldest expectation, stall at random while idle_on is set
  always @(posedge clk) begin : mon
    fire_rec_t want;
    int stall_left;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (fire_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word kind=%0d id=%02h last=%0d",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          want = fire_q.pop_front();
          if (out_tuser !== want.kind || out_tdata !== want.id ||
              out_tlast !== want.last) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d id=%02h last=%0d, %s%0d id=%02h last=%0d",
                     $time, want.kind, want.id, want.last, "got kind=",
                     out_tuser, out_tdata, out_tlast);
          end
          if (want.kind == ptts_pkg::KIND_REJECT) reject_seen++;
          else fired_seen++;
        end
        stall_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : stim
    int r;
    logic [ptts_pkg::DLY_W-1:0] dly;
    logic rep;
    logic en;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero and max delay, zero-interval repeater, periodic task, deadline tie
    push_item(ptts_pkg::OP_ADD, 8'h00, 24'h000000, 1'b0);
    push_item(ptts_pkg::OP_ADD, 8'hFF, 24'hFFFFFF, 1'b0);
    push_item(ptts_pkg::OP_ADD, 8'hA5, 24'h000000, 1'b1);
    push_item(ptts_pkg::OP_ADD, 8'h5A, 24'h000002, 1'b1);
    push_item(ptts_pkg::OP_ADD, 8'h11, 24'h000001, 1'b0);
    push_item(ptts_pkg::OP_ADD, 8'h22, 24'h000001, 1'b0);
    repeat (3) push_item(ptts_pkg::OP_TICK, 8'h00, 24'h000000, 1'b0);
    // fill the table, later slots due earlier, then two adds that bounce
    for (int k = 0; k < 13; k++)
      push_item(ptts_pkg::OP_ADD, ptts_pkg::ID_W'(k * 19 + 3),
                ptts_pkg::DLY_W'(13 - k), 1'b0);
    push_item(ptts_pkg::OP_ADD, 8'hFE, 24'h000005, 1'b1);
    push_item(ptts_pkg::OP_ADD, 8'h01, 24'h000001, 1'b0);
    push_item(ptts_pkg::OP_TICK, 8'hFF, 24'hFFFFFF, 1'b1);
    wait_idle();

    // Ticks while disabled change nothing; adds still land
    write_enable(1'b0);
    push_item(ptts_pkg::OP_TICK, 8'h33, 24'h000003, 1'b0);
    push_item(ptts_pkg::OP_ADD, 8'h44, 24'h000000, 1'b0);
    push_item(ptts_pkg::OP_TICK, 8'h55, 24'h000000, 1'b1);
    wait_idle();
    write_enable(1'b1);
    for (int k = 0; k < 4; k++) push_item(ptts_pkg::OP_TICK, 8'h00, 24'h000000, 1'b0);
    wait_idle();

    // Random phases, mostly short one-shot delays so the table keeps turning over
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p % 3) != 1;
      if (p == 2) en = 1'b0;
      else if (p == PHASES - 1) en = 1'b1;
      else en = ($urandom_range(0, 3) != 0);
      write_enable(en);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 1) == 1) begin
          // tick words carry random payload that must be ignored
          push_item(ptts_pkg::OP_TICK, ptts_pkg::ID_W'($urandom),
                    ptts_pkg::DLY_W'($urandom), 1'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 4 && sticky < STICKY_MAX) begin
            dly = ptts_pkg::DLY_W'($urandom);
            rep = 1'($urandom);
            sticky++;
          end else if (r < 16 && sticky < STICKY_MAX) begin
            dly = ptts_pkg::DLY_W'($urandom_range(0, 6));
            rep = 1'b1;
            sticky++;
          end else begin
            dly = ptts_pkg::DLY_W'($urandom_range(0, 12));
            rep = 1'b0;
          end
          push_item(ptts_pkg::OP_ADD, ptts_pkg::ID_W'($urandom), dly, rep);
        end
      end
      wait_idle();
    end

    $display("tb: %0d words sent, %0d enable writes", words_sent, cfg_writes);
    $display("tb: %0d task fires and %0d rejected adds checked", fired_seen, reject_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
